@@ design/dsw_pkg.sv @@
`default_nettype none

package dsw_pkg;

    localparam int YEAR_W  = 14;
    localparam int DAY_W   = 7;
    localparam int MONTH_W = 7;
    localparam int POS_W   = 4;
    localparam int CHAR_W  = 8;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [YEAR_W-1:0] FIRST_YEAR     = 14'd1601;
    localparam logic [YEAR_W-1:0] YEAR_MAX_RESET = 14'd3000;

    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [POS_W-1:0] POS_SEP_FIRST  = 4'd2;
    localparam logic [POS_W-1:0] POS_SEP_SECOND = 4'd5;
    localparam logic [POS_W-1:0] POS_STRING_LEN = 4'd10;
    localparam logic [POS_W-1:0] POS_SATURATE   = 4'd11;

    // register index, taken from paddr[2]
    localparam logic [0:0] REG_YEAR_MAX = 1'b0;

    // floor(x/100) = (x * 5243) >> 19 for x below 43699
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    // floor(x/7) = (x * 18725) >> 17 for 14-bit x
    localparam int DIV7_MUL     = 18725;
    localparam int DIV7_SHIFT   = 17;

    typedef struct packed {
        logic                fmt_ok;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } t_date;

    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] days;
        unique case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    function automatic logic [4:0] days_in_month(input logic [3:0] month);
        logic [4:0] days;
        unique case (month)
            4'd2:                      days = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        days = 5'd31;
            default:                   days = 5'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

@@ design/dsw_front.sv @@
`default_nettype none

module dsw_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire  [dsw_pkg::CHAR_W-1:0]  i_char_code,
    input  wire                         i_is_last,
    input  wire                         i_queue_full,
    output logic                        o_push,
    output dsw_pkg::t_date              o_rec
);

    logic [dsw_pkg::POS_W-1:0]   r_pos,   n_pos;
    logic [dsw_pkg::DAY_W-1:0]   r_day,   n_day;
    logic [dsw_pkg::MONTH_W-1:0] r_month, n_month;
    logic [dsw_pkg::YEAR_W-1:0]  r_year,  n_year;
    logic [dsw_pkg::CHAR_W-1:0]  r_sep,   n_sep;
    logic                        r_err,   n_err;

    logic       w_digit;
    logic [3:0] w_dv;
    logic       w_char_err;
    logic       w_accept;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && i_is_last;

    always_comb begin
        w_digit    = (i_char_code >= dsw_pkg::CHAR_ZERO) && (i_char_code <= dsw_pkg::CHAR_NINE);
        w_dv       = i_char_code[3:0];
        w_char_err = 1'b0;
        n_day      = r_day;
        n_month    = r_month;
        n_year     = r_year;
        n_sep      = r_sep;

        if (r_pos == dsw_pkg::POS_SEP_FIRST) begin
            n_sep      = i_char_code;
            w_char_err = (i_char_code != dsw_pkg::CHAR_SLASH) &&
                         (i_char_code != dsw_pkg::CHAR_DASH);
        end else if (r_pos == dsw_pkg::POS_SEP_SECOND) begin
            w_char_err = (i_char_code != r_sep);
        end else if (r_pos < dsw_pkg::POS_STRING_LEN) begin
            if (!w_digit) begin
                w_char_err = 1'b1;
            end else if (r_pos < dsw_pkg::POS_SEP_FIRST) begin
                n_day = 7'(10'({r_day, 3'b000}) + 10'({r_day, 1'b0}) + 10'(w_dv));
            end else if (r_pos < dsw_pkg::POS_SEP_SECOND) begin
                n_month = 7'(10'({r_month, 3'b000}) + 10'({r_month, 1'b0}) + 10'(w_dv));
            end else begin
                n_year = 14'(17'({r_year, 3'b000}) + 17'({r_year, 1'b0}) + 17'(w_dv));
            end
        end else begin
            w_char_err = 1'b1;
        end

        n_err = r_err || w_char_err;
        n_pos = (r_pos < dsw_pkg::POS_SATURATE) ? r_pos + 4'd1 : r_pos;

        o_rec.fmt_ok = (n_pos == dsw_pkg::POS_STRING_LEN) && !n_err;
        o_rec.day    = n_day;
        o_rec.month  = n_month;
        o_rec.year   = n_year;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos   <= '0;
            r_day   <= '0;
            r_month <= '0;
            r_year  <= '0;
            r_sep   <= '0;
            r_err   <= 1'b0;
        end else if (w_accept) begin
            r_pos   <= n_pos;
            r_day   <= n_day;
            r_month <= n_month;
            r_year  <= n_year;
            r_sep   <= n_sep;
            r_err   <= n_err;
        end
    end

endmodule

`default_nettype wire

@@ design/dsw_queue.sv @@
`default_nettype none

module dsw_queue #(
    parameter int DEPTH = dsw_pkg::QUEUE_DEPTH
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  dsw_pkg::t_date     i_data,
    input  wire                i_pop,
    output dsw_pkg::t_date     o_data,
    output logic               o_full,
    output logic               o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dsw_pkg::t_date     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ design/dsw_back.sv @@
`default_nettype none

module dsw_back (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire  [dsw_pkg::YEAR_W-1:0]    i_year_max,
    input  wire                           i_empty,
    input  dsw_pkg::t_date                i_rec,
    output logic                          o_pop,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic                          o_date_valid,
    output logic [2:0]                    o_weekday,
    output logic [dsw_pkg::DAY_W-1:0]     o_day_of_month,
    output logic [dsw_pkg::MONTH_W-1:0]   o_month_number,
    output logic [dsw_pkg::YEAR_W-1:0]    o_year_number
);

    logic w_adv;

    // stage 1: range checks and the divisions by 100
    logic                        r1_valid, r1_ok;
    logic [dsw_pkg::DAY_W-1:0]   r1_day;
    logic [dsw_pkg::MONTH_W-1:0] r1_month;
    logic [dsw_pkg::YEAR_W-1:0]  r1_year, r1_n;
    logic [7:0]                  r1_yq, r1_nq;

    // stage 2: leap rule, month length, day count mod-7 operand
    logic                        r2_valid, r2_ok;
    logic [dsw_pkg::DAY_W-1:0]   r2_day;
    logic [dsw_pkg::MONTH_W-1:0] r2_month;
    logic [dsw_pkg::YEAR_W-1:0]  r2_year, r2_sum;

    logic [dsw_pkg::YEAR_W-1:0]  w_n;
    logic [26:0]                 w_yprod, w_nprod;
    logic                        w_ok_a;

    logic [14:0]                 w_yq100;
    logic                        w_century, w_leap, w_leap_adj, w_ok_b;
    logic [4:0]                  w_limit;
    logic [14:0]                 w_sum;

    logic [28:0]                 w_qprod;
    logic [11:0]                 w_q;
    logic [13:0]                 w_rem;
    logic [2:0]                  w_wd;

    assign w_adv = !o_valid || i_ready;
    assign o_pop = w_adv && !i_empty;

    always_comb begin
        w_n     = i_rec.year - dsw_pkg::FIRST_YEAR;
        w_yprod = 27'(i_rec.year) * 27'(dsw_pkg::DIV100_MUL);
        w_nprod = 27'(w_n) * 27'(dsw_pkg::DIV100_MUL);
        w_ok_a  = i_rec.fmt_ok &&
                  (i_rec.month >= 7'd1) && (i_rec.month <= 7'd12) &&
                  (i_rec.year >= dsw_pkg::FIRST_YEAR) && (i_rec.year <= i_year_max) &&
                  (i_rec.day >= 7'd1) && (i_rec.day <= 7'd31);
    end

    always_comb begin
        w_yq100    = 15'(r1_yq) * 15'd100;
        w_century  = (w_yq100 == 15'(r1_year));
        w_leap     = (r1_year[1:0] == 2'b00) && (!w_century || (r1_yq[1:0] == 2'b00));
        w_leap_adj = w_leap && (r1_month > 7'd2);
        w_limit    = (r1_month == 7'd2 && w_leap) ? 5'd29
                                                  : dsw_pkg::days_in_month(r1_month[3:0]);
        w_ok_b     = r1_ok && (r1_day <= 7'(w_limit));
        // 365 is 1 mod 7, so one day per year suffices
        w_sum      = 15'(r1_n) + 15'(r1_n[13:2]) - 15'(r1_nq) + 15'(r1_nq[7:2])
                   + 15'(dsw_pkg::days_before_month(r1_month[3:0]))
                   + 15'(w_leap_adj) + 15'(r1_day) - 15'd1;
    end

    always_comb begin
        w_qprod = 29'(r2_sum) * 29'(dsw_pkg::DIV7_MUL);
        w_q     = w_qprod[28:dsw_pkg::DIV7_SHIFT];
        w_rem   = r2_sum - 14'(15'(w_q) * 15'd7);
        w_wd    = w_rem[2:0] + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= !i_empty;
            r2_valid <= r1_valid;
            o_valid  <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ok    <= w_ok_a;
            r1_day   <= i_rec.day;
            r1_month <= i_rec.month;
            r1_year  <= i_rec.year;
            r1_n     <= w_n;
            r1_yq    <= w_yprod[26:dsw_pkg::DIV100_SHIFT];
            r1_nq    <= w_nprod[26:dsw_pkg::DIV100_SHIFT];

            r2_ok    <= w_ok_b;
            r2_day   <= r1_day;
            r2_month <= r1_month;
            r2_year  <= r1_year;
            r2_sum   <= w_sum[13:0];

            o_date_valid   <= r2_ok;
            o_weekday      <= r2_ok ? w_wd     : 3'd0;
            o_day_of_month <= r2_ok ? r2_day   : '0;
            o_month_number <= r2_ok ? r2_month : '0;
            o_year_number  <= r2_ok ? r2_year  : '0;
        end
    end

endmodule

`default_nettype wire

@@ design/date_string_weekday_parser.sv @@
// The result for a string appears on o_valid after its last character is accepted, passing
// through the queue write, two check/arithmetic stages and the output register; a low i_ready stalls it.
// The front end takes one character per cycle while the queue is not full, and the fully
// pipelined back end gives one result per cycle while i_ready is high.
// Reset: synchronous, active low; clears string state, queue and pipeline, year_max = 3000.
`default_nettype none

module date_string_weekday_parser #(
    parameter int QUEUE_DEPTH = dsw_pkg::QUEUE_DEPTH
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,

    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  [dsw_pkg::CHAR_W-1:0]    i_char_code,
    input  wire                           i_is_last,

    output logic                          o_valid,
    input  wire                           i_ready,
    output logic                          o_date_valid,
    output logic [2:0]                    o_weekday,
    output logic [dsw_pkg::DAY_W-1:0]     o_day_of_month,
    output logic [dsw_pkg::MONTH_W-1:0]   o_month_number,
    output logic [dsw_pkg::YEAR_W-1:0]    o_year_number,

    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [dsw_pkg::ADDR_W-1:0]    paddr,
    input  wire  [dsw_pkg::DATA_W-1:0]    pwdata,
    output logic [dsw_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic [dsw_pkg::YEAR_W-1:0] r_year_max;

    logic           w_push, w_pop, w_full, w_empty;
    dsw_pkg::t_date w_rec_in, w_rec_out;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year_max <= dsw_pkg::YEAR_MAX_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == dsw_pkg::REG_YEAR_MAX) begin
            r_year_max <= pwdata[dsw_pkg::YEAR_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            dsw_pkg::REG_YEAR_MAX: prdata = dsw_pkg::DATA_W'(r_year_max);
            default:               prdata = '0;
        endcase
    end

    dsw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_char_code  (i_char_code),
        .i_is_last    (i_is_last),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_rec        (w_rec_in)
    );

    dsw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_rec_in),
        .i_pop   (w_pop),
        .o_data  (w_rec_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    dsw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_year_max     (r_year_max),
        .i_empty        (w_empty),
        .i_rec          (w_rec_out),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_date_valid   (o_date_valid),
        .o_weekday      (o_weekday),
        .o_day_of_month (o_day_of_month),
        .o_month_number (o_month_number),
        .o_year_number  (o_year_number)
    );

endmodule

`default_nettype wire

@@ design/dsw_checker.sv @@
`default_nettype none

module dsw_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           o_valid,
    input wire                           i_ready,
    input wire                           o_date_valid,
    input wire [2:0]                     o_weekday,
    input wire [dsw_pkg::DAY_W-1:0]      o_day_of_month,
    input wire [dsw_pkg::MONTH_W-1:0]    o_month_number,
    input wire [dsw_pkg::YEAR_W-1:0]     o_year_number
);

    // a result held against backpressure keeps its flag, weekday, day and year
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_date_valid) && $stable(o_weekday) &&
                                $stable(o_day_of_month) && $stable(o_year_number))
        else $error("result changed while stalled");

    // rejected dates carry zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_date_valid |-> o_weekday == 3'd0 && o_day_of_month == '0 &&
                                     o_month_number == '0 && o_year_number == '0)
        else $error("invalid date with non-zero fields");

    // accepted dates are in calendar range with a real weekday
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_date_valid |-> o_weekday != 3'd0 && o_month_number != '0 &&
                                    o_month_number <= 7'd12 && o_day_of_month != '0 &&
                                    o_day_of_month <= 7'd31 &&
                                    o_year_number >= dsw_pkg::FIRST_YEAR)
        else $error("valid date out of range");

    // pipeline is empty right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

endmodule

bind date_string_weekday_parser dsw_checker u_dsw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_date_valid   (o_date_valid),
    .o_weekday      (o_weekday),
    .o_day_of_month (o_day_of_month),
    .o_month_number (o_month_number),
    .o_year_number  (o_year_number)
);

`default_nettype wire
